@@ design/lts_pkg.sv @@
// ----------------------------------------------------------------------------
// lts_pkg
// shared types, codes and default sizes of the lazy tile store
// ----------------------------------------------------------------------------
package lts_pkg;

	localparam int GRID_COLUMNS_DEF = 32;
	localparam int GRID_ROWS_DEF    = 24;
	localparam int GRID_TILES_DEF   = 768;

	// width that holds any grid position computed from a screen pixel
	localparam int POS_W   = 13;
	localparam int ID_W    = 10;
	localparam int MAP_W   = 10;
	localparam int WORD_W  = 32;
	localparam int BANK_W  = 4;
	localparam int COLOR_W = 4;

	localparam logic [BANK_W-1:0] BANK_RESET = 4'hF;
	localparam logic [WORD_W-1:0] NIB_MASK   = 32'hF;

	// operation codes
	localparam logic [1:0] OP_PIXEL = 2'd0;
	localparam logic [1:0] OP_FILL  = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_QUIET   = 2'd0;
	localparam logic [1:0] KIND_DATA    = 2'd1;
	localparam logic [1:0] KIND_CLEARED = 2'd2;
	localparam logic [1:0] KIND_EXHAUST = 2'd3;

	// dirty marks
	localparam logic [1:0] MARK_NONE  = 2'd0;
	localparam logic [1:0] MARK_COPY  = 2'd1;
	localparam logic [1:0] MARK_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic [7:0]         pixel_x;
		logic [7:0]         pixel_y;
		logic [COLOR_W-1:0] color;
		logic [9:0]         tile_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [MAP_W-1:0]  map_index;
		logic [15:0]       map_value;
		logic [ID_W-1:0]   vram_id;
		logic [WORD_W-1:0] data_word;
		logic [2:0]        word_index;
		logic              last;
	} res_t;

endpackage

@@ design/lts_ram.sv @@
// ----------------------------------------------------------------------------
// lts_ram
// single-port-write, single-port-read synchronous ram, registered read data
// ----------------------------------------------------------------------------
module lts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 768,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/lazy_tile_store_with_dirty_flush_core.sv @@
// ----------------------------------------------------------------------------
// lazy_tile_store_with_dirty_flush_core
// shadow of a tile grid with lazy id allocation, dirty marks and flush
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low; each result appears on
// result for exactly one cycle with result_valid high and cannot be held off,
// so the receiver must take every cycle's result. after reset the block runs a
// clearing pass (busy high) over the id, mark and free stack memories. steps
// per item: a pixel write reads, merges and writes back one word (the whole
// tile is rewritten when it is marked for clearing or, after a new id is taken,
// when it has none); fill writes all eight words; fill with color 0 only marks
// the tile; flush streams eight data words one per cycle, or returns a cleared
// tile's id; clear-all walks the table; an off-grid item gets a quiet result.
module lazy_tile_store_with_dirty_flush_core #(
	parameter int GRID_COLUMNS = lts_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_ROWS    = lts_pkg::GRID_ROWS_DEF,
	parameter int GRID_TILES   = lts_pkg::GRID_TILES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  lts_pkg::cmd_t        cmd,
	output logic                 result_valid,
	output lts_pkg::res_t        result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [lts_pkg::BANK_W-1:0] cfg_data
);
	import lts_pkg::*;

	localparam int IW  = (GRID_TILES > 1) ? $clog2(GRID_TILES) : 1;
	localparam int FD  = (GRID_TILES > 1) ? GRID_TILES - 1 : 1;
	localparam int FAW = (FD > 1) ? $clog2(FD) : 1;
	localparam int PAW = IW + 3;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DEC    = 3'd1;
	localparam logic [2:0] ST_META   = 3'd2;
	localparam logic [2:0] ST_ALLOC  = 3'd3;
	localparam logic [2:0] ST_FILL   = 3'd4;
	localparam logic [2:0] ST_PIX    = 3'd5;
	localparam logic [2:0] ST_STREAM = 3'd6;
	localparam logic [2:0] ST_SWEEP  = 3'd7;

	logic [2:0]        state_q, state_d;
	cmd_t              cmd_q;
	logic [IW-1:0]     idx_q, idx_d;
	logic [ID_W-1:0]   id_q, id_d;
	logic [2:0]        row_q, row_d;
	logic [IW-1:0]     free_top_q, free_top_d;
	logic [IW-1:0]     sweep_q, sweep_d;
	logic              sweep_mark_q, sweep_mark_d;
	logic              sweep_emit_q, sweep_emit_d;
	logic [BANK_W-1:0] bank_q;
	res_t              res_q, res_d;
	logic              res_valid_q, res_valid_d;

	// memory ports
	logic              aid_we, aid_re;
	logic [IW-1:0]     aid_waddr, aid_raddr;
	logic [ID_W-1:0]   aid_wdata, aid_rdata;
	logic              dmk_we, dmk_re;
	logic [IW-1:0]     dmk_waddr, dmk_raddr;
	logic [1:0]        dmk_wdata, dmk_rdata;
	logic              fid_we, fid_re;
	logic [FAW-1:0]    fid_waddr, fid_raddr;
	logic [ID_W-1:0]   fid_wdata, fid_rdata;
	logic              pix_we, pix_re;
	logic [PAW-1:0]    pix_waddr, pix_raddr;
	logic [WORD_W-1:0] pix_wdata, pix_rdata;

	// grid position of the latched pixel
	logic [POS_W-1:0]  pos_full;
	logic              off_grid;
	logic [IW-1:0]     ft_dec;
	logic [4:0]        nib_sh;
	logic [WORD_W-1:0] nib_word;
	res_t              quiet;

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result       = res_q;
	assign result_valid = res_valid_q;

	assign pos_full = POS_W'(cmd_q.pixel_y[7:3]) * POS_W'(GRID_COLUMNS)
		+ POS_W'(cmd_q.pixel_x[7:3]);
	assign ft_dec   = free_top_q - 1'b1;
	assign nib_sh   = {cmd_q.pixel_x[2:0], 2'b00};
	assign nib_word = WORD_W'(cmd_q.color) << nib_sh;

	always_comb begin
		quiet      = '0;
		quiet.last = 1'b1;
	end

	always_comb begin
		off_grid = 1'b0;
		if (cmd_q.op == OP_FLUSH) begin
			off_grid = (POS_W'(cmd_q.tile_index) >= POS_W'(GRID_TILES));
		end else begin
			off_grid = (32'(cmd_q.pixel_x[7:3]) >= GRID_COLUMNS)
				|| (32'(cmd_q.pixel_y[7:3]) >= GRID_ROWS)
				|| (pos_full >= POS_W'(GRID_TILES));
		end
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		id_d         = id_q;
		row_d        = row_q;
		free_top_d   = free_top_q;
		sweep_d      = sweep_q;
		sweep_mark_d = sweep_mark_q;
		sweep_emit_d = sweep_emit_q;
		res_d        = res_q;
		res_valid_d  = 1'b0;

		aid_we = 1'b0; aid_waddr = idx_q; aid_wdata = '0;
		aid_re = 1'b0; aid_raddr = idx_q;
		dmk_we = 1'b0; dmk_waddr = idx_q; dmk_wdata = MARK_NONE;
		dmk_re = 1'b0; dmk_raddr = idx_q;
		fid_we = 1'b0; fid_waddr = free_top_q[FAW-1:0]; fid_wdata = '0;
		fid_re = 1'b0; fid_raddr = free_top_q[FAW-1:0];
		pix_we = 1'b0; pix_waddr = {idx_q, row_q}; pix_wdata = '0;
		pix_re = 1'b0; pix_raddr = {idx_q, row_q};

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				if (cmd_q.op == OP_CLEAR) begin
					free_top_d   = '0;
					sweep_d      = '0;
					sweep_mark_d = 1'b0;
					sweep_emit_d = 1'b1;
					state_d      = ST_SWEEP;
				end else if (off_grid) begin
					res_d       = quiet;
					res_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					idx_d     = (cmd_q.op == OP_FLUSH) ? IW'(cmd_q.tile_index)
						: IW'(pos_full);
					aid_re    = 1'b1;
					aid_raddr = idx_d;
					dmk_re    = 1'b1;
					dmk_raddr = idx_d;
					state_d   = ST_META;
				end
			end
			ST_META: begin
				id_d = aid_rdata;
				if (cmd_q.op == OP_FLUSH) begin
					res_d       = quiet;
					res_valid_d = 1'b1;
					state_d     = ST_IDLE;
					if (aid_rdata != '0) begin
						dmk_we = 1'b1;
						case (dmk_rdata)
							MARK_COPY: begin
								res_valid_d = 1'b0;
								row_d       = '0;
								pix_re      = 1'b1;
								pix_raddr   = {idx_q, 3'd0};
								state_d     = ST_STREAM;
							end
							MARK_CLEAR: begin
								// id goes back on the stack unless it is full
								if (free_top_q != '0) begin
									free_top_d = ft_dec;
									fid_we     = 1'b1;
									fid_waddr  = ft_dec[FAW-1:0];
									fid_wdata  = aid_rdata;
								end
								aid_we          = 1'b1;
								res_d.kind      = KIND_CLEARED;
								res_d.map_index = MAP_W'(idx_q);
								res_d.vram_id   = aid_rdata;
							end
							default: begin
							end
						endcase
					end
				end else if (cmd_q.op == OP_FILL && cmd_q.color == '0) begin
					dmk_we      = 1'b1;
					dmk_wdata   = MARK_CLEAR;
					res_d       = quiet;
					res_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end else if (aid_rdata == '0) begin
					if (({1'b0, free_top_q} + 1'b1) >= (IW + 1)'(GRID_TILES)) begin
						res_d           = quiet;
						res_d.kind      = KIND_EXHAUST;
						res_d.map_index = MAP_W'(idx_q);
						res_valid_d     = 1'b1;
						state_d         = ST_IDLE;
					end else begin
						fid_re  = 1'b1;
						state_d = ST_ALLOC;
					end
				end else begin
					dmk_we    = 1'b1;
					dmk_wdata = MARK_COPY;
					row_d     = '0;
					if (cmd_q.op == OP_FILL || dmk_rdata == MARK_CLEAR) begin
						state_d = ST_FILL;
					end else begin
						pix_re    = 1'b1;
						pix_raddr = {idx_q, cmd_q.pixel_y[2:0]};
						state_d   = ST_PIX;
					end
				end
			end
			ST_ALLOC: begin
				aid_we     = 1'b1;
				aid_wdata  = fid_rdata;
				dmk_we     = 1'b1;
				dmk_wdata  = MARK_COPY;
				free_top_d = free_top_q + 1'b1;
				row_d      = '0;
				state_d    = ST_FILL;
			end
			ST_FILL: begin
				// fill color, or a zeroed tile with the one pixel merged in
				pix_we = 1'b1;
				if (cmd_q.op == OP_FILL) begin
					pix_wdata = {8{cmd_q.color}};
				end else if (row_q == cmd_q.pixel_y[2:0]) begin
					pix_wdata = nib_word;
				end
				row_d = row_q + 1'b1;
				if (row_q == 3'd7) begin
					res_d       = quiet;
					res_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_PIX: begin
				pix_we      = 1'b1;
				pix_waddr   = {idx_q, cmd_q.pixel_y[2:0]};
				pix_wdata   = (pix_rdata & ~(NIB_MASK << nib_sh)) | nib_word;
				res_d       = quiet;
				res_valid_d = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_STREAM: begin
				res_d.kind       = KIND_DATA;
				res_d.map_index  = MAP_W'(idx_q);
				res_d.map_value  = {bank_q, 2'b00, id_q};
				res_d.vram_id    = id_q;
				res_d.data_word  = pix_rdata;
				res_d.word_index = row_q;
				res_d.last       = (row_q == 3'd7);
				res_valid_d      = 1'b1;
				if (row_q == 3'd7) begin
					state_d = ST_IDLE;
				end else begin
					row_d     = row_q + 1'b1;
					pix_re    = 1'b1;
					pix_raddr = {idx_q, row_d};
				end
			end
			ST_SWEEP: begin
				// one table entry a cycle: ids cleared, stack refilled
				aid_we    = 1'b1;
				aid_waddr = sweep_q;
				dmk_we    = sweep_mark_q;
				dmk_waddr = sweep_q;
				if (32'(sweep_q) < FD && GRID_TILES > 1) begin
					fid_we    = 1'b1;
					fid_waddr = sweep_q[FAW-1:0];
					fid_wdata = ID_W'({1'b0, sweep_q} + 1'b1);
				end
				sweep_d = sweep_q + 1'b1;
				if (32'(sweep_q) == GRID_TILES - 1) begin
					state_d = ST_IDLE;
					if (sweep_emit_q) begin
						res_d       = quiet;
						res_valid_d = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			free_top_q   <= '0;
			sweep_q      <= '0;
			sweep_mark_q <= 1'b1;
			sweep_emit_q <= 1'b0;
			bank_q       <= BANK_RESET;
			res_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			free_top_q   <= free_top_d;
			sweep_q      <= sweep_d;
			sweep_mark_q <= sweep_mark_d;
			sweep_emit_q <= sweep_emit_d;
			res_valid_q  <= res_valid_d;
			if (cfg_valid && cfg_ready) begin
				bank_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		idx_q <= idx_d;
		id_q  <= id_d;
		row_q <= row_d;
		res_q <= res_d;
	end

	lts_ram #(.WIDTH(ID_W), .DEPTH(GRID_TILES), .AW(IW)) u_aid (
		.clk(clk), .we(aid_we), .waddr(aid_waddr), .wdata(aid_wdata),
		.re(aid_re), .raddr(aid_raddr), .rdata(aid_rdata)
	);

	lts_ram #(.WIDTH(2), .DEPTH(GRID_TILES), .AW(IW)) u_dmk (
		.clk(clk), .we(dmk_we), .waddr(dmk_waddr), .wdata(dmk_wdata),
		.re(dmk_re), .raddr(dmk_raddr), .rdata(dmk_rdata)
	);

	lts_ram #(.WIDTH(ID_W), .DEPTH(FD), .AW(FAW)) u_fid (
		.clk(clk), .we(fid_we), .waddr(fid_waddr), .wdata(fid_wdata),
		.re(fid_re), .raddr(fid_raddr), .rdata(fid_rdata)
	);

	lts_ram #(.WIDTH(WORD_W), .DEPTH(GRID_TILES * 8), .AW(PAW)) u_pix (
		.clk(clk), .we(pix_we), .waddr(pix_waddr), .wdata(pix_wdata),
		.re(pix_re), .raddr(pix_raddr), .rdata(pix_rdata)
	);

endmodule
